// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define MTB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mtb assertion failed");

// property checked at every edge, reset included
`define MTB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("mtb assertion failed");

`endif

// ===== rtl/mtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtb_pkg
// types and constants of the mean threshold binarizer
// ----------------------------------------------------------------------------
`default_nettype none

package mtb_pkg;

  // channel and sum widths
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 10;
  localparam int SUM_W   = 30;
  localparam int LEVEL_W = 10;

  localparam logic [SUM_W-1:0]   SUM_MAX   = 30'h3FFF_FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd765;
  localparam logic [CHAN_W-1:0]  FULL      = 8'd255;
  localparam logic [CHAN_W-1:0]  NONE      = 8'd0;

  // action codes
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_APPLY   = 1'b1;

  // decoupling queue depth
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic              action;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic [LEVEL_W-1:0] level_used;
  } out_item_t;

  // classified work item between front and back
  typedef struct packed {
    logic             apply;
    logic [PIX_W-1:0] pix_sum;
  } work_t;

endpackage

`default_nettype wire

// ===== rtl/mtb_front.sv =====
// ----------------------------------------------------------------------------
// mtb_front
// accepts pixels, forms the channel sum and queues the classified work
// ----------------------------------------------------------------------------
`default_nettype none

module mtb_front
  import mtb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire logic     in_push,
  output logic          in_full,
  output logic          head_valid,
  output work_t         head_work,
  input  wire logic     head_take
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  work_t             queue_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              wr_en;
  logic              rd_en;
  work_t             work_in;

  // classify the incoming pixel
  always_comb begin
    work_in.apply   = (in_item.action == ACT_APPLY);
    work_in.pix_sum = PIX_W'(in_item.red) + PIX_W'(in_item.green) + PIX_W'(in_item.blue);
  end

  assign in_full    = (count_r == CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_work  = queue_r[rd_ptr_r];
  assign wr_en      = in_push && !in_full;
  assign rd_en      = head_take && head_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_r[wr_ptr_r] <= work_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtb_div.sv =====
// ----------------------------------------------------------------------------
// mtb_div
// restoring divider, one quotient bit per cycle, for the mean level
// ----------------------------------------------------------------------------
`default_nettype none

module mtb_div
  import mtb_pkg::*;
#(
  parameter int CNT_W = 21
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    done,
  output logic [LEVEL_W-1:0]      quot
);

  // the mean never exceeds the largest channel sum, so ten quotient bits do
  localparam int DIV_W  = CNT_W + LEVEL_W - 1;
  localparam int CMP_W  = (SUM_W > DIV_W) ? SUM_W : DIV_W;
  localparam int STEP_W = $clog2(LEVEL_W);

  logic [CMP_W-1:0]   rem_r, rem_nxt;
  logic [CMP_W-1:0]   dsr_r, dsr_nxt;
  logic [LEVEL_W-1:0] quot_r, quot_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               fits;

  assign fits = (dsr_r <= rem_r);

  // one compare and subtract per step
  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = CMP_W'(dividend);
      dsr_nxt  = CMP_W'(divisor) << (LEVEL_W - 1);
      quot_nxt = '0;
      step_nxt = STEP_W'(LEVEL_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? rem_r - dsr_r : rem_r;
      dsr_nxt  = dsr_r >> 1;
      quot_nxt = {quot_r[LEVEL_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/mtb_back.sv =====
// ----------------------------------------------------------------------------
// mtb_back
// accumulates the measure pass, settles the level and binarizes pixels
// ----------------------------------------------------------------------------
`default_nettype none

module mtb_back
  import mtb_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      head_valid,
  input  wire work_t     head_work,
  output logic           head_take,
  output out_item_t      out_item,
  output logic           out_empty,
  input  wire logic      out_pop
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_t;

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               applying_r, applying_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               slot_free;
  logic [SUM_W:0]     sum_wide;
  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] div_quot;
  logic [CHAN_W-1:0]  bin;

  assign slot_free = !out_valid_r || out_pop;
  assign sum_wide  = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(head_work.pix_sum);
  assign bin       = (head_work.pix_sum >= level_r) ? FULL : NONE;

  mtb_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // work sequencing
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    level_nxt     = level_r;
    applying_nxt  = applying_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    head_take     = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (head_valid) begin
          if (!head_work.apply) begin
            // measure: a new frame starts after an apply pass
            head_take = 1'b1;
            if (applying_r) begin
              applying_nxt = 1'b0;
              sum_nxt      = SUM_W'(head_work.pix_sum);
              cnt_nxt      = CNT_W'(1);
            end else if (cnt_r < CNT_W'(MAX_PIXELS)) begin
              cnt_nxt = cnt_r + 1'b1;
              sum_nxt = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
          end else if (!applying_r) begin
            // first apply of a pass settles the level
            if (cnt_r == '0) begin
              level_nxt    = '0;
              applying_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end else if (slot_free) begin
            head_take                = 1'b1;
            out_valid_nxt            = 1'b1;
            out_item_nxt.red_out     = bin;
            out_item_nxt.green_out   = bin;
            out_item_nxt.blue_out    = bin;
            out_item_nxt.level_used  = level_r;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          level_nxt    = (div_quot > LEVEL_MAX) ? LEVEL_MAX : div_quot;
          applying_nxt = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sum_r       <= '0;
      cnt_r       <= '0;
      level_r     <= '0;
      applying_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      level_r     <= level_nxt;
      applying_r  <= applying_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_item  = out_item_r;
  assign out_empty = !out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/mean_threshold_binarizer_core.sv =====
// ----------------------------------------------------------------------------
// mean_threshold_binarizer_core
// An accepted pixel waits in the input queue, and an apply pixel's result is then
// registered at the result port. Throughput: 1 pixel per cycle when nothing stalls;
// the first apply pixel after a measure pass waits for the 10-step serial divider
// that forms the mean. A 4-entry queue keeps accepting pixels while the divider or
// the result port stalls. Synchronous active-low reset clears sum, count and level.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_threshold_binarizer_core
  import mtb_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire logic      in_push,
  output logic           in_full,
  output out_item_t      out_item,
  output logic           out_empty,
  input  wire logic      out_pop
);

  logic  head_valid;
  logic  head_take;
  work_t head_work;

  // front: accept and classify
  mtb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .in_push    (in_push),
    .in_full    (in_full),
    .head_valid (head_valid),
    .head_work  (head_work),
    .head_take  (head_take)
  );

  // back: accumulate, settle level, binarize
  mtb_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_work  (head_work),
    .head_take  (head_take),
    .out_item   (out_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

endmodule

`default_nettype wire

// ===== rtl/mtb_chk.sv =====
// ----------------------------------------------------------------------------
// mtb_chk
// port level checks of the binarizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mtb_chk
  import mtb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire out_item_t out_item,
  input wire logic      out_empty,
  input wire logic      out_pop
);

  // a shown result is pure black or pure white
  `MTB_ASSERT(a_bin_value, clk, rst_n, !out_empty |-> (out_item.red_out == NONE || out_item.red_out == FULL))

  // all three channels agree
  `MTB_ASSERT(a_gray_equal, clk, rst_n, !out_empty |-> (out_item.green_out == out_item.red_out && out_item.blue_out == out_item.red_out))

  // the level never exceeds the largest channel sum
  `MTB_ASSERT(a_level_range, clk, rst_n, !out_empty |-> (out_item.level_used <= LEVEL_MAX))

  // reset leaves the result port empty and the input queue not full
  `MTB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (out_empty && !in_full))

  // a waiting result holds until its transfer
  `MTB_ASSERT(a_out_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))

endmodule

bind mean_threshold_binarizer_core mtb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_item  (out_item),
  .out_empty (out_empty),
  .out_pop   (out_pop)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mean threshold binarizer: frames of measure
// pixels followed by apply pixels are pushed through the input queue, a local
// model of the running mean predicts each binarized pixel, and every popped
// result is compared field by field under random sender and receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mtb_pkg::*;

  // frame bound of the default build
  localparam int unsigned FRAME_BOUND = 1048576;
  localparam int          ITEM_GOAL   = 1900;
  localparam int          HOLD_CYCLES = 120;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 20;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  in_item_t  in_item = '0;
  logic      in_push = 1'b0;
  logic      in_full;
  out_item_t out_item;
  logic      out_empty;
  logic      out_pop = 1'b0;

  mean_threshold_binarizer_core #(
    .MAX_PIXELS(FRAME_BOUND)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .in_push  (in_push),
    .in_full  (in_full),
    .out_item (out_item),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the current frame
  logic [SUM_W-1:0]   frame_sum   = '0;
  logic [20:0]        frame_count = '0;
  logic [LEVEL_W-1:0] frame_level = '0;
  bit                 applying    = 1'b0;

  out_item_t expected_pixels[$];
  int        error_count = 0;
  int        items_sent  = 0;

  // sender burst control
  int burst_left = 0;
  bit no_idle    = 1'b0;

  // receiver long hold-off requests
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  // one mismatch line and count
  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    error_count++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  // update the frame model with one accepted pixel, queue its result if any
  task automatic binarize_pixel(input in_item_t it);
    logic [9:0]         s;
    logic [SUM_W:0]     wide_sum;
    logic [SUM_W-1:0]   quot;
    out_item_t          res;
    s = 10'(it.red) + 10'(it.green) + 10'(it.blue);
    if (it.action == ACT_MEASURE) begin
      // measure after apply starts a new frame
      if (applying) begin
        frame_sum   = '0;
        frame_count = '0;
        applying    = 1'b0;
      end
      if (frame_count < FRAME_BOUND) begin
        frame_count++;
        wide_sum  = {1'b0, frame_sum} + (SUM_W + 1)'(s);
        frame_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
      end
    end else begin
      // threshold settles on the first apply pixel of a pass
      if (!applying) begin
        quot = (frame_count != 0) ? frame_sum / frame_count : '0;
        frame_level = (quot > LEVEL_MAX) ? LEVEL_MAX : quot[LEVEL_W-1:0];
        applying    = 1'b1;
      end
      res.red_out    = (s >= frame_level) ? FULL : NONE;
      res.green_out  = res.red_out;
      res.blue_out   = res.red_out;
      res.level_used = frame_level;
      expected_pixels.push_back(res);
    end
  endtask

  // threshold the next apply pixel will meet
  function automatic int next_level();
    int q;
    if (applying) return frame_level;
    if (frame_count == 0) return 0;
    q = frame_sum / frame_count;
    return (q > 765) ? 765 : q;
  endfunction

  function automatic in_item_t pix(input logic act, input int r, input int g, input int b);
    in_item_t it;
    it.action = act;
    it.red    = r[7:0];
    it.green  = g[7:0];
    it.blue   = b[7:0];
    return it;
  endfunction

  // random pixel whose channel sum is s
  function automatic in_item_t pixel_with_sum(input logic act, input int s);
    int r;
    int g;
    int rem;
    if (s < 0) s = 0;
    if (s > 765) s = 765;
    r   = $urandom_range((s > 255) ? 255 : s, (s > 510) ? s - 510 : 0);
    rem = s - r;
    g   = $urandom_range((rem > 255) ? 255 : rem, (rem > 255) ? rem - 255 : 0);
    return pix(act, r, g, rem - g);
  endfunction

  // offer one pixel until the transfer happens, then maybe idle
  task automatic push_pixel(input in_item_t it);
    int gap;
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    items_sent++;
    binarize_pixel(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(30, 1);
      gap = no_idle ? 0 : $urandom_range(8, 0);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: long hold-offs on request, otherwise a changing stall pattern
  int pop_mode  = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (hold_requests != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = $urandom_range(3, 0);
        mode_left = $urandom_range(200, 40);
      end
      mode_left--;
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(1, 0) == 1);
        2: out_pop <= ($urandom_range(7, 0) == 0);
        default: out_pop <= ($urandom_range(4, 0) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result, level_used", -1, out_item.level_used);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_item.red_out !== exp_px.red_out)
          report_mismatch("red_out", exp_px.red_out, out_item.red_out);
        if (out_item.green_out !== exp_px.green_out)
          report_mismatch("green_out", exp_px.green_out, out_item.green_out);
        if (out_item.blue_out !== exp_px.blue_out)
          report_mismatch("blue_out", exp_px.blue_out, out_item.blue_out);
        if (out_item.level_used !== exp_px.level_used)
          report_mismatch("level_used", exp_px.level_used, out_item.level_used);
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apply straight after reset sees an empty frame, threshold zero
  task automatic test_apply_after_reset();
    push_pixel(pix(ACT_APPLY, 0, 0, 0));
    push_pixel(pix(ACT_APPLY, 255, 255, 255));
  endtask

  // black and white frame, pixels right at and below the mean
  task automatic test_extremes();
    push_pixel(pix(ACT_MEASURE, 255, 255, 255));
    push_pixel(pix(ACT_MEASURE, 0, 0, 0));
    push_pixel(pix(ACT_APPLY, 127, 127, 128));
    push_pixel(pix(ACT_APPLY, 127, 127, 127));
    push_pixel(pix(ACT_APPLY, 0, 0, 0));
    push_pixel(pix(ACT_APPLY, 255, 255, 255));
  endtask

  // all-white frame gives the largest threshold
  task automatic test_full_mean();
    repeat (3) push_pixel(pix(ACT_MEASURE, 255, 255, 255));
    push_pixel(pix(ACT_APPLY, 255, 255, 255));
    push_pixel(pix(ACT_APPLY, 255, 254, 255));
  endtask

  // long frame, the mean of many random pixels
  task automatic test_long_frame();
    int lvl;
    repeat (48) push_pixel(pixel_with_sum(ACT_MEASURE, $urandom_range(765, 0)));
    repeat (6) begin
      lvl = next_level();
      push_pixel(pixel_with_sum(ACT_APPLY, lvl + $urandom_range(2, 0) - 1));
    end
  endtask

  // receiver holds off while the sender keeps offering apply pixels
  task automatic test_output_backpressure();
    int lvl;
    no_idle = 1'b1;
    repeat (4) push_pixel(pixel_with_sum(ACT_MEASURE, $urandom_range(765, 0)));
    hold_requests++;
    repeat (40) begin
      lvl = next_level();
      push_pixel(pixel_with_sum(ACT_APPLY, lvl + $urandom_range(2, 0) - 1));
    end
    no_idle = 1'b0;
  endtask

  // frames of random content, with some noise and broken passes
  task automatic test_random_frames();
    int n_meas;
    int n_apply;
    int base;
    int spread;
    int lvl;
    while (items_sent < ITEM_GOAL) begin
      no_idle = ($urandom_range(5, 0) == 0);
      if ($urandom_range(99, 0) < 85) begin
        n_meas  = $urandom_range(12, 0);
        n_apply = $urandom_range(10, 1);
        base    = $urandom_range(765, 0);
        spread  = ($urandom_range(1, 0) == 1) ? 765 : 40;
        repeat (n_meas)
          push_pixel(pixel_with_sum(ACT_MEASURE, base + $urandom_range(spread, 0) - spread / 2));
        repeat (n_apply) begin
          lvl = next_level();
          if ($urandom_range(1, 0) == 1)
            push_pixel(pixel_with_sum(ACT_APPLY, lvl + $urandom_range(2, 0) - 1));
          else
            push_pixel(pix(ACT_APPLY, $urandom_range(255, 0), $urandom_range(255, 0),
                           $urandom_range(255, 0)));
        end
      end else begin
        repeat ($urandom_range(6, 1))
          push_pixel(pix(1'($urandom_range(1, 0)), $urandom_range(255, 0),
                         $urandom_range(255, 0), $urandom_range(255, 0)));
      end
    end
  endtask

  // sequence of tests
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_apply_after_reset();
    test_extremes();
    test_full_mean();
    test_long_frame();
    test_output_backpressure();
    test_random_frames();
    in_push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/mtb_pkg.sv
rtl/mtb_front.sv
rtl/mtb_div.sv
rtl/mtb_back.sv
rtl/mean_threshold_binarizer_core.sv
rtl/mtb_chk.sv
tb/tb.sv
